/* design/wca_pkg.sv */
// Shared types, constants and register codes for the wind change alarm.
package wca_pkg;

    // Field and bus widths
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 16;
    localparam int DIR_W    = 16;
    localparam int DDELTA_W = 15;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Bearing arithmetic in hundredths of a degree
    localparam logic [DIR_W-1:0] FULL_TURN = 16'd36000;
    localparam logic [DIR_W-1:0] HALF_TURN = 16'd18000;

    // Register reset values
    localparam logic [15:0] CHECK_INTERVAL_RST  = 16'd10;
    localparam logic [15:0] NOTIFY_INTERVAL_RST = 16'd300;
    localparam logic [15:0] SPEED_LIMIT_RST     = 16'd658;
    localparam logic [15:0] STRONG_LIMIT_RST    = 16'd1317;
    localparam logic [14:0] DIR_LIMIT_RST       = 15'd4500;

    // Register indexes, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_CHECK_INTERVAL  = 3'd0,
        REG_NOTIFY_INTERVAL = 3'd1,
        REG_SPEED_LIMIT     = 3'd2,
        REG_STRONG_LIMIT    = 3'd3,
        REG_DIR_LIMIT       = 3'd4
    } wca_reg_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [15:0] check_interval;
        logic [15:0] notify_interval;
        logic [15:0] speed_change_limit;
        logic [15:0] strong_wind_limit;
        logic [14:0] direction_change_limit;
    } wca_cfg_t;

endpackage

/* design/wca_if.sv */
// Handshake interfaces for the sample channel and the result channel.
interface wca_sample_if;
    import wca_pkg::*;

    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   sample_time;
    logic                airborne;
    logic [SPEED_W-1:0]  wind_speed;
    logic [DIR_W-1:0]    wind_direction;

    modport source (output valid, sample_time, airborne, wind_speed, wind_direction,
                    input ready);
    modport sink   (input valid, sample_time, airborne, wind_speed, wind_direction,
                    output ready);
endinterface

interface wca_result_if;
    import wca_pkg::*;

    logic                valid;
    logic                ready;
    logic                alarm;
    logic                checked;
    logic                restarted;
    logic [SPEED_W-1:0]  speed_delta;
    logic [DDELTA_W-1:0] direction_delta;

    modport source (output valid, alarm, checked, restarted, speed_delta, direction_delta,
                    input ready);
    modport sink   (input valid, alarm, checked, restarted, speed_delta, direction_delta,
                    output ready);
endinterface

/* design/wca_regs.sv */
// APB-style configuration register file for the wind change alarm.
module wca_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [wca_pkg::ADDR_W-1:0] paddr,
    input  logic [wca_pkg::DATA_W-1:0] pwdata,
    output logic [wca_pkg::DATA_W-1:0] prdata,
    output logic                     pready,
    output wca_pkg::wca_cfg_t        cfg
);
    import wca_pkg::*;

    wca_cfg_t cfg_reg;
    wca_reg_t sel;
    logic     wr_en;

    assign sel    = wca_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes complete in the access cycle; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_interval         <= CHECK_INTERVAL_RST;
            cfg_reg.notify_interval        <= NOTIFY_INTERVAL_RST;
            cfg_reg.speed_change_limit     <= SPEED_LIMIT_RST;
            cfg_reg.strong_wind_limit      <= STRONG_LIMIT_RST;
            cfg_reg.direction_change_limit <= DIR_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_CHECK_INTERVAL:  cfg_reg.check_interval         <= pwdata[15:0];
                REG_NOTIFY_INTERVAL: cfg_reg.notify_interval        <= pwdata[15:0];
                REG_SPEED_LIMIT:     cfg_reg.speed_change_limit     <= pwdata[15:0];
                REG_STRONG_LIMIT:    cfg_reg.strong_wind_limit      <= pwdata[15:0];
                REG_DIR_LIMIT:       cfg_reg.direction_change_limit <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (sel)
            REG_CHECK_INTERVAL:  prdata = {16'd0, cfg_reg.check_interval};
            REG_NOTIFY_INTERVAL: prdata = {16'd0, cfg_reg.notify_interval};
            REG_SPEED_LIMIT:     prdata = {16'd0, cfg_reg.speed_change_limit};
            REG_STRONG_LIMIT:    prdata = {16'd0, cfg_reg.strong_wind_limit};
            REG_DIR_LIMIT:       prdata = {17'd0, cfg_reg.direction_change_limit};
            default:             prdata = '0;
        endcase
    end
endmodule

/* design/wind_change_alarm_top.sv */
// Top level of the wind change alarm: sample register, check logic, result register.
//
//   channel   direction  payload
//   samples   in         sample_time, airborne, wind_speed, wind_direction
//   results   out        alarm, checked, restarted, speed_delta, direction_delta
//   apb       in/out     five configuration registers at byte addresses 0..16
//
// One word per clock cycle is sustained unless the result side stalls; a word goes
// through the sample register, then the result register. Its check and state update
// happen in the same cycle, so the next word always sees the updated state.
// rst_n clears the state, the valid flags and the registers to their reset values.
// A stall on the result side holds the result register, then the sample register.
module wind_change_alarm_top (
    input  logic                       clk,
    input  logic                       rst_n,
    wca_sample_if.sink                 samples,
    wca_result_if.source               results,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wca_pkg::ADDR_W-1:0] paddr,
    input  logic [wca_pkg::DATA_W-1:0] pwdata,
    output logic [wca_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import wca_pkg::*;

    wca_cfg_t cfg;

    wca_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sample register
    logic                in_valid_reg;
    logic [TIME_W-1:0]   time_reg;
    logic                airborne_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [DIR_W-1:0]    dir_reg;

    // Block state
    logic                check_valid_reg;
    logic [TIME_W-1:0]   last_check_reg;
    logic                notify_valid_reg;
    logic [TIME_W-1:0]   last_notify_reg;
    logic [SPEED_W-1:0]  ref_speed_reg;
    logic [DIR_W-1:0]    ref_dir_reg;

    // Result register
    logic                out_valid_reg;
    logic                alarm_reg;
    logic                checked_reg;
    logic                restarted_reg;
    logic [SPEED_W-1:0]  sdelta_reg;
    logic [DDELTA_W-1:0] ddelta_reg;

    logic advance;
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;

    // Check decision: restart, interval elapsed, alarm hold-off.
    logic                active;
    logic                restart;
    logic                run;
    logic                notify_ok;
    logic                change;
    logic                fire;
    logic [TIME_W:0]     check_due;
    logic [TIME_W:0]     notify_due;

    assign check_due  = {1'b0, last_check_reg} + {17'd0, cfg.check_interval};
    assign notify_due = {1'b0, last_notify_reg} + {17'd0, cfg.notify_interval};
    assign active     = airborne_reg && (time_reg != '0);
    assign restart    = active && (!check_valid_reg || time_reg < last_check_reg);
    assign run        = restart || (active && ({1'b0, time_reg} >= check_due));
    assign notify_ok  = !notify_valid_reg || (time_reg < last_notify_reg) ||
                        ({1'b0, time_reg} >= notify_due);

    // Speed delta against the reference.
    logic [SPEED_W-1:0] sdelta;
    assign sdelta = (speed_reg >= ref_speed_reg) ? speed_reg - ref_speed_reg
                                                 : ref_speed_reg - speed_reg;

    // Bearing delta: reduce both bearings into one turn, subtract modulo a turn,
    // then fold into the half turn.
    logic [DIR_W-1:0] dir_mod;
    logic [DIR_W-1:0] ref_mod;
    logic [DIR_W:0]   dir_diff;
    logic [DIR_W:0]   dir_wrap;
    logic [DIR_W-1:0] dir_fold;
    logic [DDELTA_W-1:0] ddelta;

    assign dir_mod  = (dir_reg >= FULL_TURN) ? dir_reg - FULL_TURN : dir_reg;
    assign ref_mod  = (ref_dir_reg >= FULL_TURN) ? ref_dir_reg - FULL_TURN : ref_dir_reg;
    assign dir_diff = {1'b0, dir_mod} - {1'b0, ref_mod};
    assign dir_wrap = dir_diff[DIR_W] ? dir_diff + {1'b0, FULL_TURN} : dir_diff;
    assign dir_fold = (dir_wrap[DIR_W-1:0] > HALF_TURN) ? FULL_TURN - dir_wrap[DIR_W-1:0]
                                                        : dir_wrap[DIR_W-1:0];
    assign ddelta   = dir_fold[DDELTA_W-1:0];

    assign change = (sdelta > cfg.speed_change_limit) ||
                    ((speed_reg > cfg.strong_wind_limit) &&
                     (ddelta > cfg.direction_change_limit));
    assign fire   = run && change && !restart && notify_ok;

    // Sample register load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            time_reg     <= samples.sample_time;
            airborne_reg <= samples.airborne;
            speed_reg    <= samples.wind_speed;
            dir_reg      <= samples.wind_direction;
        end
    end

    // State update as a word moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_valid_reg  <= 1'b0;
            last_check_reg   <= '0;
            notify_valid_reg <= 1'b0;
            last_notify_reg  <= '0;
            ref_speed_reg    <= '0;
            ref_dir_reg      <= '0;
        end
        else if (advance && run)
        begin
            check_valid_reg <= 1'b1;
            last_check_reg  <= time_reg;
            if (restart)
            begin
                notify_valid_reg <= 1'b0;
            end
            else if (fire)
            begin
                notify_valid_reg <= 1'b1;
                last_notify_reg  <= time_reg;
            end
            if (restart || fire)
            begin
                ref_speed_reg <= speed_reg;
                ref_dir_reg   <= dir_reg;
            end
        end
    end

    // Result register; all fields read zero when no check ran.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            alarm_reg     <= fire;
            checked_reg   <= run;
            restarted_reg <= restart;
            sdelta_reg    <= run ? sdelta : '0;
            ddelta_reg    <= run ? ddelta : '0;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.alarm           = alarm_reg;
    assign results.checked         = checked_reg;
    assign results.restarted       = restarted_reg;
    assign results.speed_delta     = sdelta_reg;
    assign results.direction_delta = ddelta_reg;
endmodule

/* design/wca_checker.sv */
// Port-level assertions for the wind change alarm, bound to the top level.
module wca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        alarm,
    input logic        checked,
    input logic        restarted,
    input logic [15:0] speed_delta,
    input logic [14:0] direction_delta
);
    // No result word is offered straight after reset.
    a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result word offered after reset");

    // A restart always counts as a check and never raises the alarm.
    a_restart_checked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && restarted) |-> (checked && !alarm))
        else $error("restart without check, or with alarm");

    // An alarm needs a check.
    a_alarm_checked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alarm) |-> checked)
        else $error("alarm without check");

    // Without a check both deltas are zero.
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !checked) |-> (speed_delta == 16'd0 && direction_delta == 15'd0))
        else $error("deltas reported without check");

    // The folded bearing delta never passes half a turn.
    a_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direction_delta <= 15'd18000))
        else $error("bearing delta beyond half turn");
endmodule

bind wind_change_alarm_top wca_checker u_wca_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (results.valid),
    .alarm           (results.alarm),
    .checked         (results.checked),
    .restarted       (results.restarted),
    .speed_delta     (results.speed_delta),
    .direction_delta (results.direction_delta)
);

/* test/wind_change_alarm_top_tb.sv */
// Self-checking testbench for the wind change alarm: directed flights, then randomised ones.
module wind_change_alarm_top_tb;
    import wca_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          TURN        = 36000;
    localparam int          HALF        = 18000;
    // An address past the last register; writes to it must change nothing.
    localparam logic [2:0]  SPARE_REG   = 3'd5;

    // What one result word should carry
    typedef struct packed {
        logic                alarm;
        logic                checked;
        logic                restarted;
        logic [SPEED_W-1:0]  speed_delta;
        logic [DDELTA_W-1:0] direction_delta;
    } verdict_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    wca_sample_if sample_bus ();
    wca_result_if result_bus ();

    wind_change_alarm_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .results (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Our own copy of the registers and of the alarm state.
    wca_cfg_t            limits = {CHECK_INTERVAL_RST, NOTIFY_INTERVAL_RST, SPEED_LIMIT_RST,
                                   STRONG_LIMIT_RST, DIR_LIMIT_RST};
    logic                checked_once  = 1'b0;
    logic [TIME_W-1:0]   last_check_s  = '0;
    logic                notified_once = 1'b0;
    logic [TIME_W-1:0]   last_notify_s = '0;
    logic [SPEED_W-1:0]  ref_speed     = '0;
    logic [DIR_W-1:0]    ref_bearing   = '0;

    verdict_t            expected_verdicts[$];
    int                  errors = 0;
    int                  cycles = 0;
    logic                steady_feed = 1'b0;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Works out the result of one accepted sample and advances the alarm state.
    function automatic verdict_t wind_verdict(input logic [TIME_W-1:0] t, input logic air,
                                              input logic [SPEED_W-1:0] spd,
                                              input logic [DIR_W-1:0] dir);
        verdict_t    v;
        logic [32:0] check_due;
        logic [32:0] notify_due;
        logic        change;
        int          turn;
        v = '0;
        if (air && t != 0)
        begin
            check_due = {1'b0, last_check_s} + limits.check_interval;
            // First sample, or the clock went backwards: start afresh.
            if (!checked_once || t < last_check_s)
            begin
                notified_once = 1'b0;
                v.restarted = 1'b1;
                v.checked = 1'b1;
            end
            else if ({1'b0, t} >= check_due)
            begin
                v.checked = 1'b1;
            end
        end
        if (v.checked)
        begin
            last_check_s = t;
            checked_once = 1'b1;
            v.speed_delta = (spd >= ref_speed) ? spd - ref_speed : ref_speed - spd;
            // Bearing difference reduced to one turn, then folded to 0..180 degrees.
            turn = ((int'(dir) - int'(ref_bearing)) % TURN + TURN) % TURN;
            if (turn > HALF)
                turn = TURN - turn;
            v.direction_delta = turn[DDELTA_W-1:0];
            change = (v.speed_delta > limits.speed_change_limit) ||
                     (spd > limits.strong_wind_limit &&
                      v.direction_delta > limits.direction_change_limit);
            notify_due = {1'b0, last_notify_s} + limits.notify_interval;
            if (change && !v.restarted &&
                (!notified_once || t < last_notify_s || {1'b0, t} >= notify_due))
            begin
                last_notify_s = t;
                notified_once = 1'b1;
                v.alarm = 1'b1;
            end
            if (v.alarm || v.restarted)
            begin
                ref_speed = spd;
                ref_bearing = dir;
            end
        end
        return v;
    endfunction

    // Offers one sample word after a random gap and records its verdict once taken.
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic air,
                               input logic [SPEED_W-1:0] spd, input logic [DIR_W-1:0] dir);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (steady_feed || r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(11, 40);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid <= 1'b1;
        sample_bus.sample_time <= t;
        sample_bus.airborne <= air;
        sample_bus.wind_speed <= spd;
        sample_bus.wind_direction <= dir;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        expected_verdicts.push_back(wind_verdict(t, air, spd, dir));
    endtask

    // Stops offering words and waits for every outstanding result.
    task automatic go_idle();
        sample_bus.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CHECK_INTERVAL:  limits.check_interval = value[15:0];
            REG_NOTIFY_INTERVAL: limits.notify_interval = value[15:0];
            REG_SPEED_LIMIT:     limits.speed_change_limit = value[15:0];
            REG_STRONG_LIMIT:    limits.strong_wind_limit = value[15:0];
            REG_DIR_LIMIT:       limits.direction_change_limit = value[14:0];
            default:             ;
        endcase
    endtask

    // Sets bits above the register width now and then; they must be dropped.
    function automatic logic [DATA_W-1:0] with_noise(input logic [DATA_W-1:0] v,
                                                     input logic [DATA_W-1:0] keep);
        return ($urandom_range(0, 3) == 0) ? (v | ($urandom() & ~keep)) : v;
    endfunction

    // Grounded samples and samples with no time, then the first sample restarts.
    task automatic test_ignored_and_restart();
        send_sample(32'd0, 1'b1, 16'hFFFF, 16'hFFFF);
        send_sample(32'd100, 1'b0, 16'd1000, 16'd9000);
        send_sample(32'd100, 1'b1, 16'd1000, 16'd9000);
        send_sample(32'd105, 1'b1, 16'd5000, 16'd0);
    endtask

    // Speed change at and just past the limit, held back and released by the notify timer.
    task automatic test_speed_limit();
        send_sample(32'd110, 1'b1, 16'd1658, 16'd9000);
        send_sample(32'd120, 1'b1, 16'd1659, 16'd9000);
        send_sample(32'd130, 1'b1, 16'd0, 16'd9000);
        send_sample(32'd420, 1'b1, 16'd0, 16'd9000);
    endtask

    // Bearing swings: at the limit, light wind, wrap past north, bearings beyond a turn.
    task automatic test_bearing_swing();
        send_sample(32'd720, 1'b1, 16'd1318, 16'd9000);
        send_sample(32'd1020, 1'b1, 16'd1318, 16'd13500);
        send_sample(32'd1030, 1'b1, 16'd1318, 16'd13501);
        send_sample(32'd1330, 1'b1, 16'd1317, 16'd0);
        send_sample(32'd1340, 1'b1, 16'd1318, 16'd35999);
        send_sample(32'd1640, 1'b1, 16'd1318, 16'hFFFF);
        send_sample(32'd1940, 1'b1, 16'd1318, 16'd29535);
        send_sample(32'd1950, 1'b1, 16'd1318, 16'd47535);
    endtask

    // Interval sums that run past the top of the time range are never reached.
    task automatic test_time_overflow();
        send_sample(32'd5, 1'b1, 16'd0, 16'd0);
        go_idle();
        write_register(REG_CHECK_INTERVAL, 32'd65535);
        write_register(REG_NOTIFY_INTERVAL, 32'd65535);
        send_sample(32'hFFFF_0001, 1'b1, 16'hFFFF, 16'd18000);
        send_sample(32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0);
        go_idle();
        write_register(REG_CHECK_INTERVAL, 32'd0);
        write_register(SPARE_REG, 32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0);
        send_sample(32'd1, 1'b1, 16'hFFFF, 16'd35999);
    endtask

    // A flight under one register setting: mostly advancing time near the check
    // interval and winds near the reference, with restarts, jumps and noise mixed in.
    task automatic test_random_flight(input int phase, input int count);
        logic [TIME_W-1:0]  now_s;
        logic [TIME_W-1:0]  t;
        logic               air;
        int                 flying;
        int                 r;
        int                 lim;
        int                 s;
        int                 d;
        go_idle();
        steady_feed = ($urandom_range(0, 3) == 0);
        case (phase)
            0:
            begin
                write_register(REG_CHECK_INTERVAL, 32'd0);
                write_register(REG_NOTIFY_INTERVAL, 32'd0);
                write_register(REG_SPEED_LIMIT, 32'd0);
                write_register(REG_STRONG_LIMIT, 32'd0);
                write_register(REG_DIR_LIMIT, 32'd0);
            end
            1:
            begin
                write_register(REG_CHECK_INTERVAL, 32'd65535);
                write_register(REG_NOTIFY_INTERVAL, 32'd65535);
                write_register(REG_SPEED_LIMIT, 32'd65535);
                write_register(REG_STRONG_LIMIT, 32'd65535);
                write_register(REG_DIR_LIMIT, 32'd32767);
            end
            default:
            begin
                r = $urandom_range(0, 9);
                write_register(REG_CHECK_INTERVAL, with_noise(
                    (r < 2) ? $urandom_range(0, 3) : (r < 9) ? $urandom_range(1, 30) :
                    $urandom_range(0, 65535), 32'h0000_FFFF));
                r = $urandom_range(0, 9);
                write_register(REG_NOTIFY_INTERVAL, with_noise(
                    (r < 2) ? 32'd0 : (r < 9) ? $urandom_range(1, 600) :
                    $urandom_range(0, 65535), 32'h0000_FFFF));
                r = $urandom_range(0, 9);
                write_register(REG_SPEED_LIMIT, with_noise(
                    (r < 9) ? $urandom_range(0, 2000) : $urandom_range(0, 65535),
                    32'h0000_FFFF));
                r = $urandom_range(0, 9);
                write_register(REG_STRONG_LIMIT, with_noise(
                    (r < 9) ? $urandom_range(0, 3000) : $urandom_range(0, 65535),
                    32'h0000_FFFF));
                r = $urandom_range(0, 9);
                write_register(REG_DIR_LIMIT, with_noise(
                    (r < 9) ? $urandom_range(0, 18000) : $urandom_range(0, 32767),
                    32'h0000_7FFF));
                if ($urandom_range(0, 3) == 0)
                    write_register(SPARE_REG, $urandom());
            end
        endcase
        now_s = ($urandom_range(0, 9) < 3) ? $urandom() : $urandom_range(1, 1000);
        flying = 0;
        while (flying < count)
        begin
            // Time of the sample
            r = $urandom_range(0, 99);
            air = 1'b1;
            if (r < 3)
            begin
                if (r == 0)
                    t = '0;
                else
                begin
                    t = $urandom();
                    air = 1'b0;
                end
            end
            else
            begin
                if (r < 6)
                    now_s = (now_s > 1) ? $urandom_range(1, now_s - 1) : 32'd1;
                else if (r < 10)
                    now_s += $urandom_range(0, 200000);
                else if (r < 12)
                    now_s = $urandom();
                else
                    now_s += $urandom_range(0, 2 * int'(limits.check_interval) + 1);
                t = now_s;
            end
            // Speed: near the reference, near the strong wind limit, or anywhere
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                lim = int'(limits.speed_change_limit);
                s = int'(ref_speed) + int'($urandom_range(0, 2 * lim + 2)) - (lim + 1);
            end
            else if (r < 6)
                s = int'(limits.strong_wind_limit) + int'($urandom_range(0, 4)) - 2;
            else if (r < 9)
                s = $urandom_range(0, 65535);
            else
                s = ($urandom_range(0, 1) == 0) ? 0 : 65535;
            s = (s < 0) ? 0 : (s > 65535) ? 65535 : s;
            // Bearing: a swing around the reference, any valid bearing, or any pattern
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                lim = int'(limits.direction_change_limit);
                d = int'(ref_bearing) + int'($urandom_range(0, 2 * lim + 2)) - (lim + 1);
                d = (d % TURN + TURN) % TURN;
            end
            else if (r < 9)
                d = $urandom_range(0, TURN - 1);
            else
                d = $urandom_range(0, 65535);
            send_sample(t, air, s[15:0], d[15:0]);
            if (air && t != 0)
                flying++;
        end
    endtask

    // Result side: random stalls, short and long, with stretches of no stalling.
    initial
    begin
        int open_left;
        int stall_left;
        int r;
        open_left = 0;
        stall_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (open_left > 0)
            begin
                open_left--;
                result_bus.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    open_left = $urandom_range(20, 120);
                else if (r < 8)
                    stall_left = $urandom_range(8, 40);
                result_bus.ready <= (r < 5) || ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Compares every result word taken with the oldest outstanding verdict.
    always @(posedge clk)
    begin : verdict_checker
        verdict_t got;
        verdict_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.alarm = result_bus.alarm;
            got.checked = result_bus.checked;
            got.restarted = result_bus.restarted;
            got.speed_delta = result_bus.speed_delta;
            got.direction_delta = result_bus.direction_delta;
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: result word with none outstanding, got %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (got.alarm !== want.alarm)
                begin
                    $display("%0t: alarm expected %0b, got %0b", $time, want.alarm,
                             got.alarm);
                    errors++;
                end
                if (got.checked !== want.checked)
                begin
                    $display("%0t: checked expected %0b, got %0b", $time, want.checked,
                             got.checked);
                    errors++;
                end
                if (got.restarted !== want.restarted)
                begin
                    $display("%0t: restarted expected %0b, got %0b", $time, want.restarted,
                             got.restarted);
                    errors++;
                end
                if (got.speed_delta !== want.speed_delta)
                begin
                    $display("%0t: speed_delta expected %0d, got %0d", $time,
                             want.speed_delta, got.speed_delta);
                    errors++;
                end
                if (got.direction_delta !== want.direction_delta)
                begin
                    $display("%0t: direction_delta expected %0d, got %0d", $time,
                             want.direction_delta, got.direction_delta);
                    errors++;
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_bus.valid = 1'b0;
        sample_bus.sample_time = '0;
        sample_bus.airborne = 1'b0;
        sample_bus.wind_speed = '0;
        sample_bus.wind_direction = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_and_restart();
        test_speed_limit();
        test_bearing_swing();
        test_time_overflow();
        for (int phase = 0; phase < 12; phase++)
            test_random_flight(phase, 155);

        go_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
